[sv/tsc_pkg.sv]
package tsc_pkg;

	localparam int unsigned MAIN_CELLS  = 6;
	localparam int unsigned CROSS_CELLS = 8;
	localparam int unsigned CELL_MAX    = 32;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] REG_GREEN_TICKS       = 2'd0;
	localparam logic [1:0] REG_YELLOW_TICKS      = 2'd1;
	localparam logic [1:0] REG_MAIN_QUEUE_LIMIT  = 2'd2;
	localparam logic [1:0] REG_CROSS_QUEUE_LIMIT = 2'd3;

	localparam logic [7:0] GREEN_TICKS_RST       = 8'd12;
	localparam logic [3:0] YELLOW_TICKS_RST      = 4'd2;
	localparam logic [3:0] MAIN_QUEUE_LIMIT_RST  = 4'd2;
	localparam logic [3:0] CROSS_QUEUE_LIMIT_RST = 4'd2;

	typedef enum logic [1:0] {
		LIGHT_OFF    = 2'd0,
		LIGHT_RED    = 2'd1,
		LIGHT_YELLOW = 2'd2,
		LIGHT_GREEN  = 2'd3
	} light_t;

	typedef logic [MAIN_CELLS-1:0]  main_cells_t;
	typedef logic [CROSS_CELLS-1:0] cross_cells_t;
	typedef logic [CELL_MAX-1:0]    cells_t;

	typedef struct packed {
		logic north_arrival;
		logic south_arrival;
		logic east_arrival;
		logic west_arrival;
	} arrival_t;

	typedef struct packed {
		light_t       north_light;
		light_t       south_light;
		light_t       east_light;
		light_t       west_light;
		main_cells_t  north_waiting;
		main_cells_t  south_waiting;
		cross_cells_t east_waiting;
		cross_cells_t west_waiting;
		main_cells_t  north_moving;
		main_cells_t  south_moving;
		cross_cells_t east_moving;
		cross_cells_t west_moving;
	} result_t;

	typedef struct packed {
		light_t north;
		light_t south;
		light_t east;
		light_t west;
	} lights_t;

	typedef struct packed {
		logic [7:0] green_ticks;
		logic [3:0] yellow_ticks;
	} timing_t;

	// Light plan for the step being taken, and whether traffic moves in it.
	typedef struct packed {
		lights_t lights;
		logic    move;
	} step_t;

	typedef struct packed {
		cells_t queue;
		cells_t lane;
	} lane_t;

	function automatic cells_t reverse_cells(cells_t v, int unsigned n);
		cells_t r;
		r = '0;
		for (int i = 0; i < CELL_MAX; i++) begin
			if (i < n) begin
				r[i] = v[n-1-i];
			end
		end
		return r;
	endfunction

	// One move of an approach whose stop line is cell n-1. On red the cars of the
	// unbroken run at the stop line stay and every other car advances one cell.
	function automatic lane_t lane_fwd(cells_t q, cells_t l, logic green, int unsigned n);
		cells_t stay;
		cells_t nq;
		cells_t nl;
		stay = '0;
		nq   = '0;
		nl   = '0;
		for (int i = CELL_MAX - 1; i >= 0; i--) begin
			if (i < n) begin
				stay[i] = q[i] & ((i == n - 1) ? 1'b1 : stay[i+1]);
			end
		end
		for (int i = 0; i < CELL_MAX; i++) begin
			if (i < n) begin
				if (i == 0) begin
					nl[i] = green & q[n-1];
					nq[i] = green ? 1'b0 : (q[i] & stay[i]);
				end else begin
					nl[i] = l[i-1];
					nq[i] = green ? q[i-1] : ((q[i] & stay[i]) | (q[i-1] & ~stay[i-1]));
				end
			end
		end
		return '{queue: nq, lane: nl};
	endfunction

	function automatic lane_t lane_step(cells_t q, cells_t l, logic green, logic forward,
		int unsigned n);
		lane_t r;
		if (forward) begin
			r = lane_fwd(q, l, green, n);
		end else begin
			r = lane_fwd(reverse_cells(q, n), reverse_cells(l, n), green, n);
			r.queue = reverse_cells(r.queue, n);
			r.lane  = reverse_cells(r.lane, n);
		end
		return r;
	endfunction

endpackage

[sv/tsc_arrival_if.sv]
interface tsc_arrival_if;
	import tsc_pkg::*;

	logic     valid;
	logic     ready;
	arrival_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[sv/tsc_result_if.sv]
interface tsc_result_if;
	import tsc_pkg::*;

	logic    valid;
	logic    ready;
	result_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[sv/tsc_control.sv]
module tsc_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              over,
	input  tsc_pkg::timing_t  timing,
	output tsc_pkg::step_t    plan,
	output tsc_pkg::lights_t  lights
);
	import tsc_pkg::*;

	typedef enum logic [1:0] {
		MODE_STOP      = 2'd0,
		MODE_TO_NORMAL = 2'd1,
		MODE_NORMAL    = 2'd2
	} mode_t;

	mode_t      mode_q;
	mode_t      mode_nxt;
	logic       parity_q;
	logic [7:0] count_q;
	logic [7:0] count_nxt;
	logic [7:0] count_dec;
	lights_t    lights_q;

	assign count_dec = count_q - 8'd1;

	always_comb begin
		mode_nxt    = mode_q;
		count_nxt   = count_q;
		plan.lights = lights_q;
		plan.move   = 1'b0;
		unique case (mode_q)
			MODE_TO_NORMAL: begin
				if (lights_q.north == LIGHT_GREEN && lights_q.south == LIGHT_GREEN) begin
					plan.lights = '{LIGHT_RED, LIGHT_RED, LIGHT_GREEN, LIGHT_GREEN};
				end else begin
					plan.lights = '{LIGHT_GREEN, LIGHT_GREEN, LIGHT_RED, LIGHT_RED};
				end
				count_nxt = timing.green_ticks;
				mode_nxt  = MODE_NORMAL;
			end
			MODE_NORMAL: begin
				if (count_q <= 8'd1) begin
					if (lights_q.north == LIGHT_YELLOW && lights_q.south == LIGHT_YELLOW) begin
						plan.lights = '{LIGHT_RED, LIGHT_RED, LIGHT_GREEN, LIGHT_GREEN};
					end else begin
						plan.lights = '{LIGHT_GREEN, LIGHT_GREEN, LIGHT_RED, LIGHT_RED};
					end
					count_nxt = timing.green_ticks;
				end else begin
					count_nxt = count_dec;
					if (count_dec <= {4'd0, timing.yellow_ticks}) begin
						// Main Street counts as the green street unless it shows red.
						if (lights_q.north != LIGHT_RED && lights_q.south != LIGHT_RED) begin
							plan.lights.north = LIGHT_YELLOW;
							plan.lights.south = LIGHT_YELLOW;
						end else begin
							plan.lights.east = LIGHT_YELLOW;
							plan.lights.west = LIGHT_YELLOW;
						end
					end else begin
						plan.move = 1'b1;
					end
				end
			end
			default: begin
				if (!parity_q) begin
					plan.lights = '{LIGHT_RED, LIGHT_RED, LIGHT_OFF, LIGHT_OFF};
				end else begin
					plan.lights = '{LIGHT_OFF, LIGHT_OFF, LIGHT_RED, LIGHT_RED};
				end
				plan.move = 1'b1;
				if (over) begin
					mode_nxt = MODE_TO_NORMAL;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_STOP;
			parity_q <= 1'b0;
			count_q  <= '0;
			lights_q <= '{LIGHT_RED, LIGHT_RED, LIGHT_RED, LIGHT_RED};
		end else if (step) begin
			mode_q   <= mode_nxt;
			parity_q <= ~parity_q;
			count_q  <= count_nxt;
			lights_q <= plan.lights;
		end
	end

	assign lights = lights_q;

endmodule

[sv/traffic_signal_controller.sv]
// Latency: the result of an item is shown in the cycle after the item is accepted.
// Throughput: one item per cycle while the result side is ready; the light sequencer and the
// bitmap moves of all four approaches finish within the cycle in which the item is accepted.
// The result register frees the input side as soon as its item is taken.
// Asynchronous reset: four-way stop, all lights red, queues and lanes empty,
// registers at their defaults, no result pending.
module traffic_signal_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	tsc_arrival_if.sink                 arrival,
	tsc_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tsc_pkg::DATA_W-1:0]  pwdata,
	output logic [tsc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import tsc_pkg::*;

	logic [7:0]   green_ticks_q;
	logic [3:0]   yellow_ticks_q;
	logic [3:0]   main_limit_q;
	logic [3:0]   cross_limit_q;
	logic [1:0]   reg_index;

	logic         out_valid_q;
	logic         accept;
	logic         over;
	timing_t      timing;
	step_t        plan;
	lights_t      lights;

	main_cells_t  north_q_q, south_q_q, north_l_q, south_l_q;
	cross_cells_t east_q_q, west_q_q, east_l_q, west_l_q;
	lane_t        north_nxt, south_nxt, east_nxt, west_nxt;
	main_cells_t  north_wait_nxt, south_wait_nxt;
	cross_cells_t east_wait_nxt, west_wait_nxt;

	assign pready    = 1'b1;
	assign reg_index = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_ticks_q  <= GREEN_TICKS_RST;
			yellow_ticks_q <= YELLOW_TICKS_RST;
			main_limit_q   <= MAIN_QUEUE_LIMIT_RST;
			cross_limit_q  <= CROSS_QUEUE_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_index)
				REG_GREEN_TICKS:       green_ticks_q  <= pwdata[7:0];
				REG_YELLOW_TICKS:      yellow_ticks_q <= pwdata[3:0];
				REG_MAIN_QUEUE_LIMIT:  main_limit_q   <= pwdata[3:0];
				REG_CROSS_QUEUE_LIMIT: cross_limit_q  <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_GREEN_TICKS:       prdata = DATA_W'(green_ticks_q);
			REG_YELLOW_TICKS:      prdata = DATA_W'(yellow_ticks_q);
			REG_MAIN_QUEUE_LIMIT:  prdata = DATA_W'(main_limit_q);
			REG_CROSS_QUEUE_LIMIT: prdata = DATA_W'(cross_limit_q);
		endcase
	end

	assign arrival.ready = !out_valid_q || result.ready;
	assign accept        = arrival.valid && arrival.ready;

	// Moves keep the number of queued cars in four-way stop, so the counts can
	// be taken before the move.
	assign over = ($countones(north_q_q) > int'(main_limit_q))
		|| ($countones(south_q_q) > int'(main_limit_q))
		|| ($countones(east_q_q) > int'(cross_limit_q))
		|| ($countones(west_q_q) > int'(cross_limit_q));

	assign timing = '{green_ticks: green_ticks_q, yellow_ticks: yellow_ticks_q};

	tsc_control u_control (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.over   (over),
		.timing (timing),
		.plan   (plan),
		.lights (lights)
	);

	always_comb begin
		north_nxt = '{queue: CELL_MAX'(north_q_q), lane: CELL_MAX'(north_l_q)};
		south_nxt = '{queue: CELL_MAX'(south_q_q), lane: CELL_MAX'(south_l_q)};
		east_nxt  = '{queue: CELL_MAX'(east_q_q), lane: CELL_MAX'(east_l_q)};
		west_nxt  = '{queue: CELL_MAX'(west_q_q), lane: CELL_MAX'(west_l_q)};
		if (plan.move) begin
			north_nxt = lane_step(CELL_MAX'(north_q_q), CELL_MAX'(north_l_q),
				plan.lights.north == LIGHT_GREEN, 1'b0, MAIN_CELLS);
			south_nxt = lane_step(CELL_MAX'(south_q_q), CELL_MAX'(south_l_q),
				plan.lights.south == LIGHT_GREEN, 1'b1, MAIN_CELLS);
			east_nxt  = lane_step(CELL_MAX'(east_q_q), CELL_MAX'(east_l_q),
				plan.lights.east == LIGHT_GREEN, 1'b1, CROSS_CELLS);
			west_nxt  = lane_step(CELL_MAX'(west_q_q), CELL_MAX'(west_l_q),
				plan.lights.west == LIGHT_GREEN, 1'b0, CROSS_CELLS);
		end
		north_wait_nxt = north_nxt.queue[MAIN_CELLS-1:0];
		south_wait_nxt = south_nxt.queue[MAIN_CELLS-1:0];
		east_wait_nxt  = east_nxt.queue[CROSS_CELLS-1:0];
		west_wait_nxt  = west_nxt.queue[CROSS_CELLS-1:0];
		// Arrivals join at the far end of their queue after the move.
		north_wait_nxt[MAIN_CELLS-1]  = north_wait_nxt[MAIN_CELLS-1] | arrival.item.north_arrival;
		south_wait_nxt[0]             = south_wait_nxt[0] | arrival.item.south_arrival;
		east_wait_nxt[0]              = east_wait_nxt[0] | arrival.item.east_arrival;
		west_wait_nxt[CROSS_CELLS-1]  = west_wait_nxt[CROSS_CELLS-1] | arrival.item.west_arrival;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			north_q_q   <= '0;
			south_q_q   <= '0;
			east_q_q    <= '0;
			west_q_q    <= '0;
			north_l_q   <= '0;
			south_l_q   <= '0;
			east_l_q    <= '0;
			west_l_q    <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				north_q_q   <= north_wait_nxt;
				south_q_q   <= south_wait_nxt;
				east_q_q    <= east_wait_nxt;
				west_q_q    <= west_wait_nxt;
				north_l_q   <= north_nxt.lane[MAIN_CELLS-1:0];
				south_l_q   <= south_nxt.lane[MAIN_CELLS-1:0];
				east_l_q    <= east_nxt.lane[CROSS_CELLS-1:0];
				west_l_q    <= west_nxt.lane[CROSS_CELLS-1:0];
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.item  = '{
		north_light:   lights.north,
		south_light:   lights.south,
		east_light:    lights.east,
		west_light:    lights.west,
		north_waiting: north_q_q,
		south_waiting: south_q_q,
		east_waiting:  east_q_q,
		west_waiting:  west_q_q,
		north_moving:  north_l_q,
		south_moving:  south_l_q,
		east_moving:   east_l_q,
		west_moving:   west_l_q
	};

endmodule

[sv/tsc_checker.sv]
module tsc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              arrival_valid,
	input logic              arrival_ready,
	input logic              south_arrival,
	input logic              result_valid,
	input logic              result_ready,
	input tsc_pkg::result_t  result_item
);
	import tsc_pkg::*;

	// An accepted item always leaves a result for the next cycle.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		arrival_valid && arrival_ready |=> result_valid)
		else $error("accepted item produced no result");

	// An empty result slot never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> arrival_ready)
		else $error("input stalled with no result pending");

	// A southbound arrival is always seen in the entry cell of its queue.
	a_south_entry: assert property (@(posedge clk) disable iff (!arst_n)
		arrival_valid && arrival_ready && south_arrival |=> result_item.south_waiting[0])
		else $error("southbound arrival missing from its queue");

	// Both approaches of a street always show the same light, and the streets
	// are never green together.
	a_light_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_item.north_light == result_item.south_light)
			&& (result_item.east_light == result_item.west_light)
			&& !(result_item.north_light == LIGHT_GREEN
				&& result_item.east_light == LIGHT_GREEN))
		else $error("inconsistent light pattern");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("pending result changed before it was taken");

endmodule

bind traffic_signal_controller tsc_checker u_tsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.arrival_valid (arrival.valid),
	.arrival_ready (arrival.ready),
	.south_arrival (arrival.item.south_arrival),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_item   (result.item)
);

[sim/tb.sv]
module tb;
	import tsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 150;
	localparam int HOLD_AFTER  = 300;
	localparam int SETTLE      = 3;

	typedef enum logic [1:0] {
		SIG_FOUR_WAY = 2'd0,
		SIG_ENTERING = 2'd1,
		SIG_NORMAL   = 2'd2
	} signal_mode_t;

	typedef enum logic [1:0] {
		ROW_ITEM    = 2'd0,
		ROW_CHECKED = 2'd1,
		ROW_WRITE   = 2'd2
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		arrival_t   arrivals;
		logic [1:0] reg_index;
		logic [7:0] value;
		result_t    expected;
	} stim_row_t;

	typedef struct packed {
		logic [7:0]  green;
		logic [3:0]  yellow;
		logic [3:0]  main_limit;
		logic [3:0]  cross_limit;
		logic [15:0] items;
	} signal_plan_t;

	typedef struct packed {
		logic [31:0] queue;
		logic [31:0] lane;
	} approach_t;

	typedef struct packed {
		logic    typed;
		result_t state;
	} offer_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	tsc_arrival_if arrival_bus ();
	tsc_result_if  result_bus ();

	traffic_signal_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.arrival (arrival_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Directed opening: fill every queue as a four-way stop with the limits out of reach,
	// then lower the cross limit so the full eastbound queue starts normal mode, and run
	// two short phases so that yellow and both street swaps are seen.
	stim_row_t directed_rows [30] = '{
		'{ROW_WRITE, '0, REG_MAIN_QUEUE_LIMIT, 8'd15, '0},
		'{ROW_WRITE, '0, REG_CROSS_QUEUE_LIMIT, 8'd15, '0},
		'{ROW_CHECKED, 4'b0000, '0, '0, '{LIGHT_RED, LIGHT_RED, LIGHT_OFF, LIGHT_OFF,
			6'h00, 6'h00, 8'h00, 8'h00, 6'h00, 6'h00, 8'h00, 8'h00}},
		'{ROW_CHECKED, 4'b1111, '0, '0, '{LIGHT_OFF, LIGHT_OFF, LIGHT_RED, LIGHT_RED,
			6'h20, 6'h01, 8'h01, 8'h80, 6'h00, 6'h00, 8'h00, 8'h00}},
		'{ROW_CHECKED, 4'b0000, '0, '0, '{LIGHT_RED, LIGHT_RED, LIGHT_OFF, LIGHT_OFF,
			6'h10, 6'h02, 8'h02, 8'h40, 6'h00, 6'h00, 8'h00, 8'h00}},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_WRITE, '0, REG_GREEN_TICKS, 8'd4, '0},
		'{ROW_WRITE, '0, REG_YELLOW_TICKS, 8'd1, '0},
		'{ROW_WRITE, '0, REG_CROSS_QUEUE_LIMIT, 8'd7, '0},
		'{ROW_ITEM, 4'b0000, '0, '0, '0},
		'{ROW_ITEM, 4'b0101, '0, '0, '0},
		'{ROW_ITEM, 4'b1010, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0},
		'{ROW_ITEM, 4'b0000, '0, '0, '0},
		'{ROW_ITEM, 4'b0110, '0, '0, '0},
		'{ROW_ITEM, 4'b1001, '0, '0, '0},
		'{ROW_ITEM, 4'b0011, '0, '0, '0},
		'{ROW_ITEM, 4'b1100, '0, '0, '0},
		'{ROW_ITEM, 4'b0000, '0, '0, '0},
		'{ROW_ITEM, 4'b1111, '0, '0, '0}
	};

	// Random phases. A green time of 0 or 1, or no yellow at all, leaves Main Street
	// green for good, since the swap never finds it yellow.
	signal_plan_t timing_plan [7] = '{
		'{8'd12, 4'd2, 4'd2, 4'd2, 16'd80},
		'{8'd2, 4'd1, 4'd0, 4'd0, 16'd60},
		'{8'd255, 4'd15, 4'd15, 4'd15, 16'd280},
		'{8'd1, 4'd0, 4'd0, 4'd15, 16'd30},
		'{8'd0, 4'd0, 4'd15, 4'd0, 16'd20},
		'{8'd6, 4'd0, 4'd3, 4'd9, 16'd40},
		'{8'd20, 4'd15, 4'd1, 4'd1, 16'd40}
	};

	// Predicted intersection state and register copies.
	signal_mode_t sig_mode;
	logic         parity;
	logic [7:0]   countdown;
	light_t       north_lt, south_lt, east_lt, west_lt;
	logic [31:0]  north_q, south_q, east_q, west_q;
	logic [31:0]  north_l, south_l, east_l, west_l;
	logic [7:0]   cfg_green;
	logic [3:0]   cfg_yellow, cfg_main_limit, cfg_cross_limit;

	result_t expected_states [$];
	offer_t  offered [$];
	int      mismatches;
	int      items_accepted;
	int      results_checked;
	int      burst_left;
	int      cycle_count;
	logic    long_hold_done;

	// One move of an approach. The stop line is the top cell when stop_at_top is set,
	// else cell 0. On red the unbroken run at the stop line holds and the rest close up.
	function automatic approach_t advance_approach(logic [31:0] q, logic [31:0] l,
		logic green, logic stop_at_top, int n);
		logic [31:0] mask;
		logic [31:0] stay;
		logic        run;
		approach_t   r;
		mask = (32'd1 << n) - 32'd1;
		stay = '0;
		run  = 1'b1;
		if (stop_at_top) begin
			for (int i = n - 1; i >= 0; i--) begin
				run     = run & q[i];
				stay[i] = run;
			end
			r.lane = (l << 1) & mask;
			if (green) begin
				r.lane[0] = q[n-1];
				r.queue   = (q << 1) & mask;
			end else begin
				r.queue = (q & stay) | (((q & ~stay) << 1) & mask);
			end
		end else begin
			for (int i = 0; i < n; i++) begin
				run     = run & q[i];
				stay[i] = run;
			end
			r.lane = l >> 1;
			if (green) begin
				r.lane[n-1] = q[0];
				r.queue     = q >> 1;
			end else begin
				r.queue = (q & stay) | ((q & ~stay) >> 1);
			end
		end
		return r;
	endfunction

	function automatic void move_traffic();
		approach_t a;
		a = advance_approach(north_q, north_l, north_lt == LIGHT_GREEN, 1'b0, MAIN_CELLS);
		north_q = a.queue;
		north_l = a.lane;
		a = advance_approach(south_q, south_l, south_lt == LIGHT_GREEN, 1'b1, MAIN_CELLS);
		south_q = a.queue;
		south_l = a.lane;
		a = advance_approach(east_q, east_l, east_lt == LIGHT_GREEN, 1'b1, CROSS_CELLS);
		east_q = a.queue;
		east_l = a.lane;
		a = advance_approach(west_q, west_l, west_lt == LIGHT_GREEN, 1'b0, CROSS_CELLS);
		west_q = a.queue;
		west_l = a.lane;
	endfunction

	function automatic void show_streets(light_t main_color, light_t cross_color);
		north_lt = main_color;
		south_lt = main_color;
		east_lt  = cross_color;
		west_lt  = cross_color;
	endfunction

	function automatic result_t tick_intersection(arrival_t a);
		result_t r;
		case (sig_mode)
			SIG_ENTERING: begin
				if (north_lt == LIGHT_GREEN && south_lt == LIGHT_GREEN) begin
					show_streets(LIGHT_RED, LIGHT_GREEN);
				end else begin
					show_streets(LIGHT_GREEN, LIGHT_RED);
				end
				countdown = cfg_green;
				sig_mode  = SIG_NORMAL;
			end
			SIG_NORMAL: begin
				if (countdown <= 8'd1) begin
					if (north_lt == LIGHT_YELLOW && south_lt == LIGHT_YELLOW) begin
						show_streets(LIGHT_RED, LIGHT_GREEN);
					end else begin
						show_streets(LIGHT_GREEN, LIGHT_RED);
					end
					countdown = cfg_green;
				end else begin
					countdown = countdown - 8'd1;
					if (countdown <= {4'd0, cfg_yellow}) begin
						if (north_lt != LIGHT_RED && south_lt != LIGHT_RED) begin
							north_lt = LIGHT_YELLOW;
							south_lt = LIGHT_YELLOW;
						end else begin
							east_lt = LIGHT_YELLOW;
							west_lt = LIGHT_YELLOW;
						end
					end else begin
						move_traffic();
					end
				end
			end
			default: begin
				if (!parity) begin
					show_streets(LIGHT_RED, LIGHT_OFF);
				end else begin
					show_streets(LIGHT_OFF, LIGHT_RED);
				end
				move_traffic();
				if ($countones(north_q) > cfg_main_limit || $countones(south_q) > cfg_main_limit
						|| $countones(east_q) > cfg_cross_limit
						|| $countones(west_q) > cfg_cross_limit) begin
					sig_mode = SIG_ENTERING;
				end
			end
		endcase
		parity = ~parity;
		if (a.north_arrival) north_q[MAIN_CELLS-1] = 1'b1;
		if (a.south_arrival) south_q[0] = 1'b1;
		if (a.east_arrival) east_q[0] = 1'b1;
		if (a.west_arrival) west_q[CROSS_CELLS-1] = 1'b1;
		r.north_light   = north_lt;
		r.south_light   = south_lt;
		r.east_light    = east_lt;
		r.west_light    = west_lt;
		r.north_waiting = north_q[MAIN_CELLS-1:0];
		r.south_waiting = south_q[MAIN_CELLS-1:0];
		r.east_waiting  = east_q[CROSS_CELLS-1:0];
		r.west_waiting  = west_q[CROSS_CELLS-1:0];
		r.north_moving  = north_l[MAIN_CELLS-1:0];
		r.south_moving  = south_l[MAIN_CELLS-1:0];
		r.east_moving   = east_l[CROSS_CELLS-1:0];
		r.west_moving   = west_l[CROSS_CELLS-1:0];
		return r;
	endfunction

	function automatic void note_mismatch(string what, longint unsigned want,
		longint unsigned got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("Mismatch at result %0d, %s: expected %0h, got %0h",
				results_checked, what, want, got);
		end
	endfunction

	function automatic void check_state(result_t want, result_t got);
		if (want.north_light != got.north_light)
			note_mismatch("north_light", want.north_light, got.north_light);
		if (want.south_light != got.south_light)
			note_mismatch("south_light", want.south_light, got.south_light);
		if (want.east_light != got.east_light)
			note_mismatch("east_light", want.east_light, got.east_light);
		if (want.west_light != got.west_light)
			note_mismatch("west_light", want.west_light, got.west_light);
		if (want.north_waiting != got.north_waiting)
			note_mismatch("north_waiting", want.north_waiting, got.north_waiting);
		if (want.south_waiting != got.south_waiting)
			note_mismatch("south_waiting", want.south_waiting, got.south_waiting);
		if (want.east_waiting != got.east_waiting)
			note_mismatch("east_waiting", want.east_waiting, got.east_waiting);
		if (want.west_waiting != got.west_waiting)
			note_mismatch("west_waiting", want.west_waiting, got.west_waiting);
		if (want.north_moving != got.north_moving)
			note_mismatch("north_moving", want.north_moving, got.north_moving);
		if (want.south_moving != got.south_moving)
			note_mismatch("south_moving", want.south_moving, got.south_moving);
		if (want.east_moving != got.east_moving)
			note_mismatch("east_moving", want.east_moving, got.east_moving);
		if (want.west_moving != got.west_moving)
			note_mismatch("west_moving", want.west_moving, got.west_moving);
	endfunction

	// Items and results are both taken at the rising edge, so the values read here are
	// the ones the block saw at that edge.
	always @(posedge clk) begin
		if (result_bus.valid && result_bus.ready) begin
			results_checked++;
			if (expected_states.size() == 0) begin
				note_mismatch("result with nothing expected", 0, result_bus.item);
			end else begin
				check_state(expected_states.pop_front(), result_bus.item);
			end
		end
		if (arrival_bus.valid && arrival_bus.ready && offered.size() != 0) begin
			items_accepted++;
			if (offered[0].typed) begin
				void'(tick_intersection(arrival_bus.item));
				expected_states.push_back(offered[0].state);
			end else begin
				expected_states.push_back(tick_intersection(arrival_bus.item));
			end
			void'(offered.pop_front());
		end
	end

	task automatic send_arrival(arrival_t a, logic typed, result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				arrival_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		arrival_bus.valid <= 1'b1;
		arrival_bus.item  <= a;
		offered.push_back('{typed, want});
		do @(posedge clk); while (!arrival_bus.ready);
	endtask

	// Stop offering and let every outstanding result drain before a register write.
	task automatic settle();
		arrival_bus.valid <= 1'b0;
		burst_left = 0;
		while (expected_states.size() != 0 || offered.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({index, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (index)
			REG_GREEN_TICKS:       cfg_green = value[7:0];
			REG_YELLOW_TICKS:      cfg_yellow = value[3:0];
			REG_MAIN_QUEUE_LIMIT:  cfg_main_limit = value[3:0];
			REG_CROSS_QUEUE_LIMIT: cfg_cross_limit = value[3:0];
			default: ;
		endcase
		// Read the register straight back.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) note_mismatch("register readback", value, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int stretch;
		int style;
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
				// Long hold-off: the result register fills and the input side stalls.
				long_hold_done = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stretch = $urandom_range(4, 40);
				style   = $urandom_range(0, 3);
				repeat (stretch) begin
					case (style)
						0: result_bus.ready <= 1'b1;
						1: result_bus.ready <= 1'($urandom_range(0, 1));
						2: result_bus.ready <= ($urandom_range(0, 3) != 0);
						default: result_bus.ready <= ~result_bus.ready;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycle_count, expected_states.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [3:0] bits;
		arrival_t   a;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		arrival_bus.valid <= 1'b0;
		arrival_bus.item  <= '0;
		sig_mode        = SIG_FOUR_WAY;
		parity          = 1'b0;
		countdown       = '0;
		show_streets(LIGHT_RED, LIGHT_RED);
		north_q = '0; south_q = '0; east_q = '0; west_q = '0;
		north_l = '0; south_l = '0; east_l = '0; west_l = '0;
		cfg_green       = GREEN_TICKS_RST;
		cfg_yellow      = YELLOW_TICKS_RST;
		cfg_main_limit  = MAIN_QUEUE_LIMIT_RST;
		cfg_cross_limit = CROSS_QUEUE_LIMIT_RST;
		mismatches      = 0;
		items_accepted  = 0;
		results_checked = 0;
		burst_left      = 0;
		long_hold_done  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				write_register(directed_rows[i].reg_index, DATA_W'(directed_rows[i].value));
			end else begin
				send_arrival(directed_rows[i].arrivals, directed_rows[i].kind == ROW_CHECKED,
					directed_rows[i].expected);
			end
		end

		foreach (timing_plan[p]) begin
			settle();
			write_register(REG_GREEN_TICKS, DATA_W'(timing_plan[p].green));
			write_register(REG_YELLOW_TICKS, DATA_W'(timing_plan[p].yellow));
			write_register(REG_MAIN_QUEUE_LIMIT, DATA_W'(timing_plan[p].main_limit));
			write_register(REG_CROSS_QUEUE_LIMIT, DATA_W'(timing_plan[p].cross_limit));
			repeat (timing_plan[p].items) begin
				bits = 4'($urandom_range(0, 15));
				// Odd phases keep arrivals sparse so that queues also drain.
				if (p % 2 == 1) bits = bits & 4'($urandom_range(0, 15));
				a = bits;
				send_arrival(a, 1'b0, '0);
			end
		end
		settle();

		$display("Covered %0d arrival items over %0d timing settings: four-way stop fill,",
			items_accepted, $size(timing_plan) + 1);
		$display("entry to normal mode, yellow and swaps, and a long result hold-off; %0d %s",
			results_checked, "results checked");
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
sv/tsc_pkg.sv
sv/tsc_arrival_if.sv
sv/tsc_result_if.sv
sv/tsc_control.sv
sv/traffic_signal_controller.sv
sv/tsc_checker.sv
sim/tb.sv
